// File: design/lsds_pkg.sv
package lsds_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int WORD_W      = 64;
	localparam int FILL_W      = 8;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		REQ_PUSH  = 3'd0,
		REQ_POP   = 3'd1,
		REQ_PEEK  = 3'd2,
		REQ_DUP   = 3'd3,
		REQ_SWAP  = 3'd4,
		REQ_CLEAR = 3'd5
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_SWAP  = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_WAIT = 1'b1
	} fsm_t;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [WORD_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [WORD_W-1:0] top_value;
		logic [FILL_W-1:0] fill_level;
	} rsp_t;

endpackage

// File: design/lsds_ram.sv
module lsds_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/lifo_stack_with_dup_swap.sv
// channel   | handshake          | payload        | notes
// ----------+--------------------+----------------+------------------------------
// request   | start, busy        | req   (req_t)  | transfer when start && !busy
// result    | done               | rsp   (rsp_t)  | one-cycle strobe per result, no stall
//
// push, peek, duplicate, clear, pop of the last entry, unused codes and rejected
// requests give their result in the cycle after the transfer; pop with two or
// more entries and a successful swap first pass through the wait state, as the
// memory port that fetches the entry below the top has a registered read.
// busy is high only during that wait state.
// arst_n clears the fill count, the state machine and the result strobe;
// stored words keep no reset value.
// the receiver cannot stall: each result is shown for exactly one cycle.
module lifo_stack_with_dup_swap (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lsds_pkg::req_t req,
	output logic          done,
	output lsds_pkg::rsp_t rsp
);

	localparam int AW = lsds_pkg::ADDR_W;
	localparam int CW = lsds_pkg::CNT_W;
	localparam int DW = lsds_pkg::WORD_W;
	localparam int FW = lsds_pkg::FILL_W;

	// top of stack lives in top_q; entries below it sit in the ram at their index
	lsds_pkg::fsm_t   state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	logic [DW-1:0]    top_q, top_d;
	logic             top_en;
	logic             swap_q, swap_d;     // pending op in wait: swap (1) or pop (0)
	logic             done_q;
	lsds_pkg::rsp_t   rsp_q, rsp_d;
	logic             fin;
	logic             go_wait;

	logic             accept;
	logic             has1, has2, full;

	// ram ports
	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [DW-1:0]    ram_wdata, ram_rdata;

	assign has1 = (count_q != '0);
	assign has2 = (count_q >= CW'(2));
	assign full = (count_q == CW'(lsds_pkg::STACK_DEPTH));

	// fsm outputs
	always_comb begin
		busy   = (state_q == lsds_pkg::FSM_WAIT);
		accept = start && (state_q == lsds_pkg::FSM_IDLE);
	end

	// fsm next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lsds_pkg::FSM_IDLE: begin
				if (accept && go_wait) begin
					state_d = lsds_pkg::FSM_WAIT;
				end
			end
			lsds_pkg::FSM_WAIT: begin
				state_d = lsds_pkg::FSM_IDLE;
			end
			default: begin
				state_d = lsds_pkg::FSM_IDLE;
			end
		endcase
	end

	// request decode, memory control and result build
	always_comb begin
		count_d   = count_q;
		top_d     = top_q;
		top_en    = 1'b0;
		swap_d    = swap_q;
		go_wait   = 1'b0;
		fin       = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = AW'(count_q - CW'(1));
		ram_wdata = top_q;
		ram_re    = 1'b0;
		ram_raddr = AW'(count_q - CW'(2));
		rsp_d.status    = lsds_pkg::ST_OK;
		rsp_d.top_value = has1 ? top_q : '0;

		if (state_q == lsds_pkg::FSM_WAIT) begin
			// wait state: entry below the top has arrived
			fin    = 1'b1;
			top_d  = ram_rdata;
			top_en = 1'b1;
			if (swap_q) begin
				ram_we          = 1'b1;
				ram_waddr       = AW'(count_q - CW'(2));
				ram_wdata       = top_q;
				rsp_d.top_value = ram_rdata;
			end else begin
				count_d         = count_q - CW'(1);
				rsp_d.top_value = top_q;
			end
		end else if (accept) begin
			unique case (req.req_type)
				lsds_pkg::REQ_PUSH: begin
					fin = 1'b1;
					if (full) begin
						rsp_d.status = lsds_pkg::ST_FULL;
					end else begin
						// spill the old top below the new one
						ram_we          = has1;
						top_d           = req.push_value;
						top_en          = 1'b1;
						count_d         = count_q + CW'(1);
						rsp_d.top_value = req.push_value;
					end
				end
				lsds_pkg::REQ_POP: begin
					if (!has1) begin
						fin          = 1'b1;
						rsp_d.status = lsds_pkg::ST_EMPTY;
					end else if (!has2) begin
						// last entry: nothing to fetch
						fin     = 1'b1;
						count_d = '0;
					end else begin
						ram_re  = 1'b1;
						go_wait = 1'b1;
						swap_d  = 1'b0;
					end
				end
				lsds_pkg::REQ_PEEK: begin
					fin = 1'b1;
					if (!has1) begin
						rsp_d.status = lsds_pkg::ST_EMPTY;
					end
				end
				lsds_pkg::REQ_DUP: begin
					fin = 1'b1;
					if (!has1) begin
						rsp_d.status = lsds_pkg::ST_EMPTY;
					end else if (full) begin
						rsp_d.status = lsds_pkg::ST_FULL;
					end else begin
						ram_we  = 1'b1;
						count_d = count_q + CW'(1);
					end
				end
				lsds_pkg::REQ_SWAP: begin
					if (!has2) begin
						fin          = 1'b1;
						rsp_d.status = lsds_pkg::ST_SWAP;
					end else begin
						ram_re  = 1'b1;
						go_wait = 1'b1;
						swap_d  = 1'b1;
					end
				end
				lsds_pkg::REQ_CLEAR: begin
					fin             = 1'b1;
					count_d         = '0;
					rsp_d.top_value = '0;
				end
				default: begin
					// unused codes: state untouched
					fin = 1'b1;
				end
			endcase
		end

		rsp_d.fill_level = FW'(count_d);
	end

	lsds_ram #(
		.DEPTH (lsds_pkg::STACK_DEPTH),
		.WIDTH (DW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsds_pkg::FSM_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= fin;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (top_en) begin
			top_q <= top_d;
		end
		swap_q <= swap_d;
		if (fin) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// File: design/lsds_checker.sv
module lsds_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input lsds_pkg::rsp_t rsp
);

	// every transfer gives a result next cycle or a single busy cycle
	a_xfer_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("transfer not followed by result or busy");

	// busy lasts one cycle and ends in a result
	a_busy_ends: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("busy cycle did not end in a result");

	// no result without a preceding transfer or busy cycle
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("result without a request");

	// empty status means an empty stack
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == lsds_pkg::ST_EMPTY))
			|-> ((rsp.top_value == '0) && (rsp.fill_level == '0)))
		else $error("empty status with data");

	// swap reject only with fewer than two entries
	a_swap_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == lsds_pkg::ST_SWAP)) |-> (rsp.fill_level < 8'd2))
		else $error("swap rejected with two or more entries");

endmodule

bind lifo_stack_with_dup_swap lsds_checker u_lsds_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
